// ----- hdl/bcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the bitmask code compressor
// Payload structs of both channels, the chunk passed from classifier to
// packer, format codes and fixed sizes.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int OUT_BITS       = 32;
  localparam int DICT_SIZE      = 8;
  localparam int DICT_IDX_BITS  = 3;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CHUNK_BITS     = 40;   // run code (5) plus longest code (35)
  localparam int CODE_BITS      = 35;
  localparam int RUN_BITS       = 5;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  localparam logic [2:0] MAX_RUN        = 3'd4;
  localparam logic [4:0] MASK_START_MAX = 5'd28;

  // Format prefixes, sent first
  localparam logic [2:0] FMT_RUN    = 3'b000;
  localparam logic [2:0] FMT_DIRECT = 3'b101;
  localparam logic [2:0] FMT_ONE    = 3'b010;
  localparam logic [2:0] FMT_ADJ    = 3'b011;
  localparam logic [2:0] FMT_MASK   = 3'b001;
  localparam logic [2:0] FMT_TWO    = 3'b100;
  localparam logic [2:0] FMT_ORIG   = 3'b110;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        end_of_program;
  } instr_item_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic        final_word;
  } packed_item_t;

  // Code bits of one transaction, left-aligned, zero below len
  typedef struct packed {
    logic [CHUNK_BITS-1:0] bits;
    logic [5:0]            len;
    logic                  last;
  } chunk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage : bcc_pkg
`default_nettype wire

// ----- hdl/bitmask_code_compressor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmask_code_compressor: dictionary-based code compressor, top level
// Codes 32-bit instruction words against an 8-word dictionary and packs the
// codes MSB-first into 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   dictionary; index 0..7 selects the entry, higher indexes are ignored.
//   Write it only while the block is idle. cfg_ready is always high.
//   Input channel (instr_valid/instr_stall, instr_item) takes one word per
//   transaction; end_of_program marks the last word of a program.
//   Output channel (packed_valid/packed_stall, packed_item) delivers packed
//   words; final_word flags the last word of a program.
// Path: a word's code bits go from its queue slot into the packer's held
//   bits and then into the output register (classify into queue, pack into
//   held bits, send from output register).
// Throughput: one input transaction per cycle while the packer keeps up;
//   the packer sends one 32-bit word per cycle unless stalled, so long codes
//   (35 bits) or end-of-program padding can add a second or third word.
// Reset: rst (synchronous) clears run state, queue, held bits and the
//   dictionary (all entries zero).
// Stall: packed_stall holds the output register; the packer and then the
//   4-entry queue fill, after which instr_stall rises.
// ----------------------------------------------------------------------------
module bitmask_code_compressor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input words
  input  wire logic                               instr_valid,
  output logic                                    instr_stall,
  input  wire bcc_pkg::instr_item_t               instr_item,
  // packed output words
  output logic                                    packed_valid,
  input  wire logic                               packed_stall,
  output bcc_pkg::packed_item_t                   packed_item,
  // dictionary writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                        cfg_data
);
  import bcc_pkg::*;

  logic          push;
  logic          pop;
  chunk_t        wr_chunk;
  chunk_t        head;
  queue_status_t q_status;

  // Dictionary registers take a write every cycle
  assign cfg_ready   = 1'b1;
  // Hold input while the queue has no free slot
  assign instr_stall = q_status.full;

  // Front: run detection and format selection
  bcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_item  (instr_item),
    .queue_full  (q_status.full),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .chunk       (wr_chunk)
  );

  // Queue: decouples classification from packing
  bcc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_chunk (wr_chunk),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back: bit packing, padding and output register
  bcc_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_avail   (!q_status.empty),
    .pop          (pop),
    .packed_valid (packed_valid),
    .packed_stall (packed_stall),
    .packed_item  (packed_item)
  );

  // Queue cannot be full and empty at once
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // Packer takes a transaction only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("packer popped an empty queue");

  // No push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("front pushed into a full queue");

  // A queued chunk never claims more bits than it carries
  a_chunk_len: assert property (@(posedge clk) disable iff (rst)
    !q_status.empty |-> (head.len <= 6'(CHUNK_BITS)))
    else $error("queued chunk length out of range");

endmodule : bitmask_code_compressor
`default_nettype wire

// ----- hdl/bcc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_front: run tracking and dictionary classification
// Holds the dictionary and the run state, and turns each accepted word into
// a chunk of code bits for the packer queue.
// ----------------------------------------------------------------------------
module bcc_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                instr_valid,
  input  wire bcc_pkg::instr_item_t                instr_item,
  input  wire logic                                queue_full,
  input  wire logic                                cfg_valid,
  input  wire logic [bcc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [31:0]                         cfg_data,
  output logic                                     push,
  output bcc_pkg::chunk_t                          chunk
);
  import bcc_pkg::*;

  logic [31:0] dict [DICT_SIZE];
  logic [31:0] prev_word;
  logic        have_prev;
  logic [2:0]  repeat_count;

  logic [31:0] prev_word_next;
  logic        have_prev_next;
  logic [2:0]  repeat_count_next;

  logic [31:0] w;
  logic        last;
  logic        accept;
  logic        is_rep;
  logic [2:0]  rc_inc;
  logic        run_emit;
  logic        code_emit;
  logic [1:0]  run_cnt;

  logic [31:0] x    [DICT_SIZE];
  logic [31:0] xs   [DICT_SIZE];
  logic [4:0]  p1   [DICT_SIZE];
  logic [4:0]  p2   [DICT_SIZE];
  logic [4:0]  s    [DICT_SIZE];
  logic [DICT_SIZE-1:0] f_direct, f_one, f_adj, f_mask, f_two;

  logic [CODE_BITS-1:0] code_bits;
  logic [5:0]           code_len;
  logic [CODE_BITS-1:0] code_sent;
  logic [5:0]           code_len_sent;
  logic [DICT_IDX_BITS-1:0] idx;

  // Position (from the left) of the leftmost set bit
  function automatic logic [4:0] lead_pos(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd31;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) p = 5'(31 - b);
    end
    return p;
  endfunction

  // Position (from the left) of the rightmost set bit
  function automatic logic [4:0] trail_pos(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd31;
    for (int b = 31; b >= 0; b--) begin
      if (v[b]) p = 5'(31 - b);
    end
    return p;
  endfunction

  function automatic logic [DICT_IDX_BITS-1:0] lowest(input logic [DICT_SIZE-1:0] f);
    logic [DICT_IDX_BITS-1:0] k;
    k = '0;
    for (int i = DICT_SIZE - 1; i >= 0; i--) begin
      if (f[i]) k = DICT_IDX_BITS'(i);
    end
    return k;
  endfunction

  assign w      = instr_item.instr_word;
  assign last   = instr_item.end_of_program;
  assign accept = instr_valid && !queue_full;

  // Per-entry mismatch analysis, all entries in parallel
  always_comb begin
    for (int i = 0; i < DICT_SIZE; i++) begin
      x[i]  = w ^ dict[i];
      p1[i] = lead_pos(x[i]);
      p2[i] = trail_pos(x[i]);
      s[i]  = (p1[i] > MASK_START_MAX) ? MASK_START_MAX : p1[i];
      xs[i] = x[i] << s[i];
      f_direct[i] = (x[i] == 32'd0);
      f_one[i]    = (x[i] != 32'd0) && ((x[i] & (x[i] - 32'd1)) == 32'd0);
      f_two[i]    = ((x[i] & (x[i] - 32'd1)) != 32'd0) &&
                    (((x[i] & (x[i] - 32'd1)) & ((x[i] & (x[i] - 32'd1)) - 32'd1)) == 32'd0);
      f_adj[i]    = f_two[i] && ((x[i] & (x[i] >> 1)) != 32'd0);
      f_mask[i]   = (x[i] != 32'd0) && (xs[i][27:0] == 28'd0);
    end
  end

  // Pick the first format that fits, lowest index inside it
  always_comb begin
    idx       = '0;
    code_bits = {FMT_ORIG, w};
    code_len  = 6'd35;
    if (f_direct != '0) begin
      idx       = lowest(f_direct);
      code_bits = {FMT_DIRECT, idx, 29'd0};
      code_len  = 6'd6;
    end else if (f_one != '0) begin
      idx       = lowest(f_one);
      code_bits = {FMT_ONE, p1[idx], idx, 24'd0};
      code_len  = 6'd11;
    end else if (f_adj != '0) begin
      idx       = lowest(f_adj);
      code_bits = {FMT_ADJ, p1[idx], idx, 24'd0};
      code_len  = 6'd11;
    end else if (f_mask != '0) begin
      idx       = lowest(f_mask);
      code_bits = {FMT_MASK, s[idx], xs[idx][31:28], idx, 20'd0};
      code_len  = 6'd15;
    end else if (f_two != '0) begin
      idx       = lowest(f_two);
      code_bits = {FMT_TWO, p1[idx], p2[idx], idx, 19'd0};
      code_len  = 6'd16;
    end
  end

  // Run handling and next state
  always_comb begin
    rc_inc            = repeat_count + 3'd1;
    is_rep            = have_prev && (w == prev_word) && (repeat_count < MAX_RUN);
    run_emit          = 1'b0;
    run_cnt           = 2'd0;
    code_emit         = 1'b0;
    prev_word_next    = prev_word;
    have_prev_next    = have_prev;
    repeat_count_next = repeat_count;
    if (is_rep) begin
      if (rc_inc == MAX_RUN) begin
        run_emit          = 1'b1;
        run_cnt           = 2'd3;
        have_prev_next    = 1'b0;
        repeat_count_next = 3'd0;
      end else begin
        run_emit          = last;
        run_cnt           = repeat_count[1:0];
        repeat_count_next = rc_inc;
      end
    end else begin
      run_emit          = (repeat_count != 3'd0);
      run_cnt           = repeat_count[1:0] - 2'd1;
      code_emit         = 1'b1;
      prev_word_next    = w;
      have_prev_next    = 1'b1;
      repeat_count_next = 3'd0;
    end
    if (last) begin
      prev_word_next    = 32'd0;
      have_prev_next    = 1'b0;
      repeat_count_next = 3'd0;
    end
  end

  assign code_sent     = code_emit ? code_bits : '0;
  assign code_len_sent = code_emit ? code_len : 6'd0;

  always_comb begin
    chunk.bits = run_emit ? {FMT_RUN, run_cnt, code_sent} : {code_sent, RUN_BITS'(0)};
    chunk.len  = (run_emit ? 6'(RUN_BITS) : 6'd0) + code_len_sent;
    chunk.last = last;
  end

  // Drop transactions that add no bits and end nothing
  assign push = accept && ((chunk.len != 6'd0) || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_word    <= 32'd0;
      have_prev    <= 1'b0;
      repeat_count <= 3'd0;
      for (int i = 0; i < DICT_SIZE; i++) dict[i] <= 32'd0;
    end else begin
      if (cfg_valid && (cfg_index < CFG_INDEX_BITS'(DICT_SIZE))) begin
        dict[cfg_index[DICT_IDX_BITS-1:0]] <= cfg_data;
      end
      if (accept) begin
        prev_word    <= prev_word_next;
        have_prev    <= have_prev_next;
        repeat_count <= repeat_count_next;
      end
    end
  end

endmodule : bcc_front
`default_nettype wire

// ----- hdl/bcc_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_fifo: short chunk queue between classifier and packer
// Register-based, fixed depth, head shown combinationally.
// ----------------------------------------------------------------------------
module bcc_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire bcc_pkg::chunk_t        wr_chunk,
  input  wire logic                   pop,
  output bcc_pkg::chunk_t             head,
  output bcc_pkg::queue_status_t      status
);
  import bcc_pkg::*;

  chunk_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_chunk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_PTR_BITS+1)'(1);
        2'b01:   count <= count - (QUEUE_PTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule : bcc_fifo
`default_nettype wire

// ----- hdl/bcc_packer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_packer: bit packer and output register
// Appends each chunk to the held bits, pads at end of program, and sends
// one 32-bit word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bcc_packer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bcc_pkg::chunk_t       head,
  input  wire logic                  head_avail,
  output logic                       pop,
  output logic                       packed_valid,
  input  wire logic                  packed_stall,
  output bcc_pkg::packed_item_t      packed_item
);
  import bcc_pkg::*;

  localparam int WORK_BITS = 3 * OUT_BITS;

  logic [WORK_BITS-1:0] work;        // held bits, left-aligned
  logic [1:0]           words_left;  // full words still to send from work
  logic [4:0]           fill;        // bits left over once they are sent
  logic                 work_last;

  logic                 out_free;
  logic                 emit;
  logic                 load_ok;
  logic [WORK_BITS-1:0] cur;
  logic [WORK_BITS-1:0] acc;
  logic [WORK_BITS-1:0] acc_pad;
  logic [6:0]           acc_len;
  logic [6:0]           padded_len;

  function automatic logic [WORK_BITS-1:0] top_mask(input logic [6:0] n);
    return ~({WORK_BITS{1'b1}} >> n);
  endfunction

  assign out_free = !packed_valid || !packed_stall;
  assign emit     = (words_left != 2'd0) && out_free;
  assign load_ok  = (words_left == 2'd0) || ((words_left == 2'd1) && emit);
  assign pop      = head_avail && load_ok;

  // Merge the new chunk behind the leftover bits
  always_comb begin
    cur        = emit ? (work << OUT_BITS) : work;
    acc        = {cur[WORK_BITS-1 -: OUT_BITS], {(WORK_BITS-OUT_BITS){1'b0}}} |
                 ({head.bits, {(WORK_BITS-CHUNK_BITS){1'b0}}} >> fill);
    acc_len    = 7'(fill) + 7'(head.len);
    padded_len = head.last ? ((acc_len + 7'd31) & 7'b1100000) : acc_len;
    acc_pad    = acc | (top_mask(padded_len) & ~top_mask(acc_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work         <= '0;
      words_left   <= 2'd0;
      fill         <= 5'd0;
      work_last    <= 1'b0;
      packed_valid <= 1'b0;
    end else begin
      if (emit) begin
        packed_valid            <= 1'b1;
        packed_item.packed_word <= work[WORK_BITS-1 -: OUT_BITS];
        packed_item.final_word  <= work_last && (words_left == 2'd1);
      end else if (!packed_stall) begin
        packed_valid <= 1'b0;
      end
      if (pop) begin
        work       <= acc_pad;
        words_left <= padded_len[6:5];
        fill       <= head.last ? 5'd0 : acc_len[4:0];
        work_last  <= head.last;
      end else if (emit) begin
        work       <= work << OUT_BITS;
        words_left <= words_left - 2'd1;
      end
    end
  end

endmodule : bcc_packer
`default_nettype wire
